// ===== rtl/bal_pkg.sv =====
// ----------------------------------------------------------------------------
// bal_pkg
// Shared types and constants for the bounded array list core: request and
// result payloads, opcodes and the control word broadcast to the cell row.
// ----------------------------------------------------------------------------
package bal_pkg;

  localparam int OPCODE_W   = 4;
  localparam int DATA_W     = 32;
  localparam int POS_W      = 8;
  localparam int COUNT_W    = 9;
  localparam int IDX_W      = 13;
  localparam int MAX_ELEM_W = 64;
  localparam int GROUP_SIZE = 16;

  localparam logic [OPCODE_W-1:0] OP_INS_HEAD  = 4'd0;
  localparam logic [OPCODE_W-1:0] OP_INS_TAIL  = 4'd1;
  localparam logic [OPCODE_W-1:0] OP_RM_HEAD   = 4'd2;
  localparam logic [OPCODE_W-1:0] OP_RM_TAIL   = 4'd3;
  localparam logic [OPCODE_W-1:0] OP_RM_AT     = 4'd4;
  localparam logic [OPCODE_W-1:0] OP_READ_AT   = 4'd5;
  localparam logic [OPCODE_W-1:0] OP_READ_HEAD = 4'd6;
  localparam logic [OPCODE_W-1:0] OP_READ_TAIL = 4'd7;
  localparam logic [OPCODE_W-1:0] OP_CLEAR     = 4'd8;

  typedef struct packed {
    logic [OPCODE_W-1:0] opcode;
    logic [DATA_W-1:0]   elem_value;
    logic [POS_W-1:0]    position;
  } bal_req_t;

  typedef struct packed {
    logic [DATA_W-1:0]  read_data;
    logic               ok;
    logic [COUNT_W-1:0] count;
  } bal_res_t;

  typedef struct packed {
    logic                  up;
    logic                  dn;
    logic                  wr;
    logic [IDX_W-1:0]      dn_from;
    logic [IDX_W-1:0]      wr_idx;
    logic [MAX_ELEM_W-1:0] value;
  } bal_cell_ctrl_t;

endpackage

// ===== rtl/bal_cell.sv =====
// ----------------------------------------------------------------------------
// bal_cell
// One list slot: holds an element, takes its lower or upper neighbor's word
// on a shift, loads a new word on a tail write (cell 0 also on a head insert),
// and offers its word to the read bus when its index is selected.
// ----------------------------------------------------------------------------
module bal_cell
  import bal_pkg::*;
#(
  parameter int IDX    = 0,
  parameter int ELEM_W = 32
) (
  input  logic                 clk,
  input  bal_cell_ctrl_t       ctrl_i,
  input  logic [ELEM_W-1:0]    prev_i,
  input  logic [ELEM_W-1:0]    next_i,
  input  logic [IDX_W-1:0]     rd_idx_i,
  output logic [ELEM_W-1:0]    data_o,
  output logic [ELEM_W-1:0]    sel_o
);

  localparam logic [IDX_W-1:0] MY_IDX = IDX_W'(IDX);

  logic [ELEM_W-1:0] data_r;
  logic [ELEM_W-1:0] data_nxt;

  always_comb begin
    data_nxt = data_r;
    if (ctrl_i.up) begin
      data_nxt = (MY_IDX == '0) ? ctrl_i.value[ELEM_W-1:0] : prev_i;
    end else if (ctrl_i.wr && (MY_IDX == ctrl_i.wr_idx)) begin
      data_nxt = ctrl_i.value[ELEM_W-1:0];
    end else if (ctrl_i.dn && (MY_IDX >= ctrl_i.dn_from)) begin
      data_nxt = next_i;
    end
  end

  always_ff @(posedge clk) begin
    data_r <= data_nxt;
  end

  assign data_o = data_r;
  assign sel_o  = (MY_IDX == rd_idx_i) ? data_r : '0;

endmodule

// ===== rtl/bal_grp.sv =====
// ----------------------------------------------------------------------------
// bal_grp
// Registered OR reduction over one group of cell read outputs; at most one
// cell in the row drives a nonzero word.
// ----------------------------------------------------------------------------
module bal_grp #(
  parameter int N = 16,
  parameter int W = 32
) (
  input  logic              clk,
  input  logic [N-1:0][W-1:0] din_i,
  output logic [W-1:0]      dout_r
);

  logic [W-1:0] dout_nxt;

  always_comb begin
    dout_nxt = '0;
    for (int i = 0; i < N; i++) begin
      dout_nxt = dout_nxt | din_i[i];
    end
  end

  always_ff @(posedge clk) begin
    dout_r <= dout_nxt;
  end

endmodule

// ===== rtl/bounded_array_list_core.sv =====
// ----------------------------------------------------------------------------
// bounded_array_list_core
// Bounded ordered list kept in a row of shifting cells, with a count.
// ----------------------------------------------------------------------------
// A request (opcode, element word, position) is taken on a clock edge with
// start high and busy low. Inserts, removals and clear update the count at
// that same edge, and inserts and head or positional removals update the cell row;
// a shift loads every cell from its neighbor in parallel at any fill level.
// Each request gives exactly one result (read data, ok flag, count after the
// operation) on out_res, marked by out_valid for one cycle. The result
// comes through the read path: the selected cell's word goes through a
// registered OR stage over groups of sixteen cells, then an OR over the
// groups that is registered into out_res.
// busy is high while a request is in the s1 or s2 stage, so a new request
// is not taken until the previous one has left them; the result of the
// previous request is delivered in the cycle the next one may be taken.
// The result receiver cannot stall: out_valid lasts one cycle.
// Reset clears the count and the pipeline valids; cell contents are left as
// they are, and no slot at or beyond the count is ever read.
// ----------------------------------------------------------------------------
module bounded_array_list_core
  import bal_pkg::*;
#(
  parameter int CAPACITY = 256,
  parameter int ELEM_W   = 32
) (
  input  logic     clk,
  input  logic     rst_n,
  input  logic     start,
  output logic     busy,
  input  bal_req_t in_req,
  output logic     out_valid,
  output bal_res_t out_res
);

  localparam int CW = $clog2(CAPACITY + 1);
  localparam int NG = (CAPACITY + GROUP_SIZE - 1) / GROUP_SIZE;
  localparam logic [CW-1:0] CAP_CNT = CW'(CAPACITY);

  logic accept;

  logic [CW-1:0] cnt_r, cnt_nxt;
  logic          s1_v_r, s2_v_r, out_valid_r;
  logic          s1_ok_r, s2_ok_r;
  logic          s1_rd_r, s2_rd_r;
  logic [CW-1:0] s1_cnt_r, s2_cnt_r;
  logic [CW-1:0] rd_idx_r;
  bal_res_t      out_res_r;

  logic          ok_c, rd_c;
  logic [CW-1:0] rd_idx_c;
  logic          full, empty, pos_ok;
  logic [CW-1:0] pos_c;
  bal_cell_ctrl_t ctrl;

  logic [CAPACITY-1:0][ELEM_W-1:0]      cell_d;
  logic [NG*GROUP_SIZE-1:0][ELEM_W-1:0] sel_w;
  logic [NG-1:0][ELEM_W-1:0]            grp_r;
  logic [ELEM_W-1:0]                    rd_or;

  assign accept = start & ~busy;
  assign busy   = s1_v_r | s2_v_r;
  assign full   = (cnt_r == CAP_CNT);
  assign empty  = (cnt_r == '0);
  assign pos_ok = ({{CW{1'b0}}, in_req.position} < {{POS_W{1'b0}}, cnt_r});
  assign pos_c  = CW'(in_req.position);

  // request decode
  always_comb begin
    ok_c         = 1'b0;
    rd_c         = 1'b0;
    rd_idx_c     = '0;
    cnt_nxt      = cnt_r;
    ctrl.up      = 1'b0;
    ctrl.dn      = 1'b0;
    ctrl.wr      = 1'b0;
    ctrl.dn_from = '0;
    ctrl.wr_idx  = IDX_W'(cnt_r);
    ctrl.value   = MAX_ELEM_W'(in_req.elem_value);
    unique case (in_req.opcode)
      OP_INS_HEAD: begin
        ok_c    = ~full;
        ctrl.up = accept & ~full;
        if (accept && !full) cnt_nxt = cnt_r + 1'b1;
      end
      OP_INS_TAIL: begin
        ok_c    = ~full;
        ctrl.wr = accept & ~full;
        if (accept && !full) cnt_nxt = cnt_r + 1'b1;
      end
      OP_RM_HEAD: begin
        ok_c    = ~empty;
        ctrl.dn = accept & ~empty;
        if (accept && !empty) cnt_nxt = cnt_r - 1'b1;
      end
      OP_RM_TAIL: begin
        ok_c = ~empty;
        if (accept && !empty) cnt_nxt = cnt_r - 1'b1;
      end
      OP_RM_AT: begin
        ok_c         = pos_ok;
        ctrl.dn      = accept & pos_ok;
        ctrl.dn_from = IDX_W'(pos_c);
        if (accept && pos_ok) cnt_nxt = cnt_r - 1'b1;
      end
      OP_READ_AT: begin
        ok_c     = pos_ok;
        rd_c     = pos_ok;
        rd_idx_c = pos_c;
      end
      OP_READ_HEAD: begin
        ok_c = ~empty;
        rd_c = ~empty;
      end
      OP_READ_TAIL: begin
        ok_c     = ~empty;
        rd_c     = ~empty;
        rd_idx_c = cnt_r - 1'b1;
      end
      OP_CLEAR: begin
        ok_c = 1'b1;
        if (accept) cnt_nxt = '0;
      end
      default: begin
        ok_c = 1'b0;
      end
    endcase
  end

  // cell row
  for (genvar g = 0; g < CAPACITY; g++) begin : g_cell
    logic [ELEM_W-1:0] prev_w, next_w;
    if (g == 0) begin : g_first
      assign prev_w = '0;
    end else begin : g_mid_lo
      assign prev_w = cell_d[g-1];
    end
    if (g == CAPACITY - 1) begin : g_last
      assign next_w = cell_d[g];
    end else begin : g_mid_hi
      assign next_w = cell_d[g+1];
    end
    bal_cell #(
      .IDX    (g),
      .ELEM_W (ELEM_W)
    ) u_cell (
      .clk      (clk),
      .ctrl_i   (ctrl),
      .prev_i   (prev_w),
      .next_i   (next_w),
      .rd_idx_i (IDX_W'(rd_idx_r)),
      .data_o   (cell_d[g]),
      .sel_o    (sel_w[g])
    );
  end

  for (genvar p = CAPACITY; p < NG*GROUP_SIZE; p++) begin : g_pad
    assign sel_w[p] = '0;
  end

  // read reduction, first level
  for (genvar k = 0; k < NG; k++) begin : g_grp
    bal_grp #(
      .N (GROUP_SIZE),
      .W (ELEM_W)
    ) u_grp (
      .clk    (clk),
      .din_i  (sel_w[k*GROUP_SIZE +: GROUP_SIZE]),
      .dout_r (grp_r[k])
    );
  end

  always_comb begin
    rd_or = '0;
    for (int i = 0; i < NG; i++) begin
      rd_or = rd_or | grp_r[i];
    end
  end

  // control pipeline
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r       <= '0;
      s1_v_r      <= 1'b0;
      s2_v_r      <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      cnt_r       <= cnt_nxt;
      s1_v_r      <= accept;
      s2_v_r      <= s1_v_r;
      out_valid_r <= s2_v_r;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      s1_ok_r  <= ok_c;
      s1_rd_r  <= rd_c;
      s1_cnt_r <= cnt_nxt;
      rd_idx_r <= rd_idx_c;
    end
    if (s1_v_r) begin
      s2_ok_r  <= s1_ok_r;
      s2_rd_r  <= s1_rd_r;
      s2_cnt_r <= s1_cnt_r;
    end
    if (s2_v_r) begin
      out_res_r.read_data <= s2_rd_r ? DATA_W'(rd_or) : '0;
      out_res_r.ok        <= s2_ok_r;
      out_res_r.count     <= COUNT_W'(s2_cnt_r);
    end
  end

  assign out_valid = out_valid_r;
  assign out_res   = out_res_r;

`ifndef SYNTHESIS
  a_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= CAP_CNT)
    else $error("list count above capacity");

  a_pipe_order: assert property (@(posedge clk) disable iff (!rst_n)
    s1_v_r |=> (s2_v_r && !s1_v_r))
    else $error("request overlap in read pipeline");

  a_out_follows: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> $past(s2_v_r))
    else $error("result without a request in flight");

  a_nok_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_res.ok) |-> (out_res.read_data == '0))
    else $error("ignored request returned data");

  a_count_hold: assert property (@(posedge clk) disable iff (!rst_n)
    busy |=> $stable(cnt_r))
    else $error("count changed while busy");
`endif

endmodule

// ===== tb/sv/tb_bounded_array_list_core.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_bounded_array_list_core
// Self-checking bench for the bounded array list core: a queue-fed driver
// presents list requests, a shadow list predicts each result when its
// request is taken, and a monitor compares every strobed result in order.
// ----------------------------------------------------------------------------
module tb_bounded_array_list_core
  import bal_pkg::*;
();

  localparam int LIST_DEPTH     = 256;
  localparam int WATCHDOG_LIMIT = 2000;
  localparam int SETTLE_CYCLES  = 8;

  localparam logic [OPCODE_W-1:0] OP_UNUSED_LO = 4'd9;
  localparam logic [OPCODE_W-1:0] OP_UNUSED_HI = 4'd15;

  typedef struct {
    bal_req_t req;
    int       gap_pct;
    bit       drain;
  } list_cmd_t;

  logic     clk;
  logic     rst_n;
  logic     start = 1'b0;
  logic     busy;
  bal_req_t in_req = '0;
  logic     out_valid;
  bal_res_t out_res;

  list_cmd_t   pending_cmds[$];
  bal_res_t    expected_results[$];
  logic [31:0] list_words[LIST_DEPTH];
  int          list_fill = 0;
  int          gen_fill = 0;
  int          fail_count = 0;
  int          idle_cycles = 0;
  int          taken_count = 0;
  int          seen_count = 0;

  bounded_array_list_core #(
    .CAPACITY(LIST_DEPTH),
    .ELEM_W  (DATA_W)
  ) dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (start),
    .busy     (busy),
    .in_req   (in_req),
    .out_valid(out_valid),
    .out_res  (out_res)
  );

  initial clk = 1'b0;
  always #5 clk = ~clk;

  // shift elements above from down one slot
  function automatic void close_gap(int from);
    int i;
    for (i = from; i + 1 < list_fill; i++) list_words[i] = list_words[i + 1];
  endfunction

  function automatic bal_res_t apply_list_op(bal_req_t r);
    bal_res_t res;
    int       i;
    res = '0;
    case (r.opcode)
      OP_INS_HEAD: if (list_fill < LIST_DEPTH) begin
        for (i = list_fill; i > 0; i--) list_words[i] = list_words[i - 1];
        list_words[0] = r.elem_value;
        list_fill++;
        res.ok = 1'b1;
      end
      OP_INS_TAIL: if (list_fill < LIST_DEPTH) begin
        list_words[list_fill] = r.elem_value;
        list_fill++;
        res.ok = 1'b1;
      end
      OP_RM_HEAD: if (list_fill > 0) begin
        close_gap(0);
        list_fill--;
        res.ok = 1'b1;
      end
      OP_RM_TAIL: if (list_fill > 0) begin
        list_fill--;
        res.ok = 1'b1;
      end
      OP_RM_AT: if (int'(r.position) < list_fill) begin
        close_gap(int'(r.position));
        list_fill--;
        res.ok = 1'b1;
      end
      OP_READ_AT: if (int'(r.position) < list_fill) begin
        res.read_data = list_words[r.position];
        res.ok = 1'b1;
      end
      OP_READ_HEAD: if (list_fill > 0) begin
        res.read_data = list_words[0];
        res.ok = 1'b1;
      end
      OP_READ_TAIL: if (list_fill > 0) begin
        res.read_data = list_words[list_fill - 1];
        res.ok = 1'b1;
      end
      OP_CLEAR: begin
        list_fill = 0;
        res.ok = 1'b1;
      end
      default: ;
    endcase
    res.count = COUNT_W'(list_fill);
    return res;
  endfunction

  task automatic queue_cmd(input logic [OPCODE_W-1:0] op, input logic [DATA_W-1:0] val,
                           input logic [POS_W-1:0] pos, input int gap);
    list_cmd_t c;
    c.req.opcode     = op;
    c.req.elem_value = val;
    c.req.position   = pos;
    c.gap_pct        = gap;
    c.drain          = 1'b0;
    pending_cmds.push_back(c);
    // running fill level so generated positions land inside the list
    case (op) inside
      OP_INS_HEAD, OP_INS_TAIL: if (gen_fill < LIST_DEPTH) gen_fill++;
      OP_RM_HEAD, OP_RM_TAIL: if (gen_fill > 0) gen_fill--;
      OP_RM_AT: if (int'(pos) < gen_fill) gen_fill--;
      OP_CLEAR: gen_fill = 0;
      default: ;
    endcase
  endtask

  function automatic logic [DATA_W-1:0] pick_word();
    int sel;
    sel = $urandom_range(0, 19);
    if (sel == 0) return '0;
    if (sel == 1) return '1;
    return $urandom;
  endfunction

  function automatic logic [POS_W-1:0] pick_position();
    if (gen_fill > 0 && $urandom_range(0, 3) != 0) begin
      return POS_W'($urandom_range(0, gen_fill - 1));
    end
    return POS_W'($urandom_range(0, 255));
  endfunction

  task automatic queue_random_ops(input int n, input int gap);
    int k;
    int sel;
    for (k = 0; k < n; k++) begin
      sel = $urandom_range(0, 99);
      if (sel < 22) queue_cmd(OP_INS_HEAD, pick_word(), POS_W'($urandom), gap);
      else if (sel < 42) queue_cmd(OP_INS_TAIL, pick_word(), POS_W'($urandom), gap);
      else if (sel < 50) queue_cmd(OP_RM_HEAD, $urandom, POS_W'($urandom), gap);
      else if (sel < 58) queue_cmd(OP_RM_TAIL, $urandom, POS_W'($urandom), gap);
      else if (sel < 66) queue_cmd(OP_RM_AT, $urandom, pick_position(), gap);
      else if (sel < 80) queue_cmd(OP_READ_AT, $urandom, pick_position(), gap);
      else if (sel < 87) queue_cmd(OP_READ_HEAD, $urandom, POS_W'($urandom), gap);
      else if (sel < 94) queue_cmd(OP_READ_TAIL, $urandom, POS_W'($urandom), gap);
      else if (sel < 96) queue_cmd(OP_CLEAR, $urandom, POS_W'($urandom), gap);
      else queue_cmd(OPCODE_W'($urandom_range(OP_UNUSED_LO, OP_UNUSED_HI)), $urandom,
                     POS_W'($urandom), gap);
    end
  endtask

  // driver: one request on the port, replaced once taken
  always @(negedge clk) begin : drive_proc
    logic      next_start;
    bal_req_t  next_req;
    list_cmd_t popped;
    next_start = start;
    next_req   = in_req;
    if (!rst_n) begin
      next_start = 1'b0;
    end else if (!start || (taken_count != seen_count)) begin
      next_start = 1'b0;
      if (pending_cmds.size() > 0) begin
        if (pending_cmds[0].drain) begin
          if (expected_results.size() == 0) void'(pending_cmds.pop_front());
        end else if ($urandom_range(0, 99) >= pending_cmds[0].gap_pct) begin
          popped     = pending_cmds.pop_front();
          next_req   = popped.req;
          next_start = 1'b1;
        end
      end
    end
    seen_count = taken_count;
    start  <= next_start;
    in_req <= next_req;
  end

  // monitor: predict on accept, check each strobed result
  always @(posedge clk) begin : monitor_proc
    bal_res_t want;
    if (rst_n) begin
      if (start && !busy) begin
        expected_results.push_back(apply_list_op(in_req));
        taken_count++;
      end
      if (out_valid) begin
        if (expected_results.size() == 0) begin
          $display("%0t: unexpected result read_data=%08h ok=%0b count=%0d", $time,
                   out_res.read_data, out_res.ok, out_res.count);
          fail_count++;
        end else begin
          want = expected_results.pop_front();
          if (out_res.read_data !== want.read_data) begin
            $display("%0t: read_data expected %08h actual %08h", $time, want.read_data,
                     out_res.read_data);
            fail_count++;
          end
          if (out_res.ok !== want.ok) begin
            $display("%0t: ok expected %0b actual %0b", $time, want.ok, out_res.ok);
            fail_count++;
          end
          if (out_res.count !== want.count) begin
            $display("%0t: count expected %0d actual %0d", $time, want.count, out_res.count);
            fail_count++;
          end
        end
      end
    end
  end

  always @(posedge clk) begin
    if (!rst_n || (start && !busy) || out_valid) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("bounded_array_list_core: mismatch");
      $finish;
    end
  end

  initial begin : stimulus_proc
    list_cmd_t hold;
    rst_n  = 1'b0;

    // empty list corner cases
    queue_cmd(OP_READ_HEAD, 32'h0, 8'd0, 0);
    queue_cmd(OP_READ_TAIL, 32'h0, 8'd0, 0);
    queue_cmd(OP_RM_HEAD, 32'h0, 8'd0, 0);
    queue_cmd(OP_RM_TAIL, 32'h0, 8'd0, 0);
    queue_cmd(OP_RM_AT, 32'h0, 8'd0, 0);
    queue_cmd(OP_READ_AT, 32'h0, 8'd0, 0);
    // small list, extreme words
    queue_cmd(OP_INS_TAIL, 32'h0000_0000, 8'd0, 0);
    queue_cmd(OP_INS_HEAD, 32'hFFFF_FFFF, 8'd0, 0);
    queue_cmd(OP_INS_TAIL, 32'hA5A5_A5A5, 8'd0, 0);
    queue_cmd(OP_READ_AT, 32'h0, 8'd0, 0);
    queue_cmd(OP_READ_AT, 32'h0, 8'd2, 0);
    queue_cmd(OP_READ_AT, 32'h0, 8'd3, 0);
    queue_cmd(OP_READ_AT, 32'h0, 8'd255, 0);
    queue_cmd(OP_READ_HEAD, 32'h0, 8'd0, 0);
    queue_cmd(OP_READ_TAIL, 32'h0, 8'd0, 0);
    queue_cmd(OP_RM_AT, 32'h0, 8'd1, 0);
    queue_cmd(OP_RM_AT, 32'h0, 8'd200, 0);
    queue_cmd(OP_UNUSED_LO, 32'hFFFF_FFFF, 8'd255, 0);
    queue_cmd(OP_UNUSED_HI, 32'h5A5A_5A5A, 8'd0, 0);
    queue_cmd(OP_RM_HEAD, 32'h0, 8'd0, 0);
    queue_cmd(OP_RM_TAIL, 32'h0, 8'd0, 0);
    queue_cmd(OP_INS_HEAD, 32'h1234_5678, 8'd0, 0);
    queue_cmd(OP_CLEAR, 32'h0, 8'd0, 0);
    queue_cmd(OP_CLEAR, 32'h0, 8'd0, 0);
    queue_cmd(OP_RM_AT, 32'h0, 8'd0, 0);

    queue_random_ops(150, 0);

    // fill to capacity, then inserts on a full list and edge indexes
    while (gen_fill < LIST_DEPTH) begin
      if ($urandom_range(0, 9) == 0) queue_cmd(OP_READ_AT, $urandom, pick_position(), 70);
      else if ($urandom_range(0, 1) == 0) begin
        queue_cmd(OP_INS_HEAD, pick_word(), POS_W'($urandom), 70);
      end else begin
        queue_cmd(OP_INS_TAIL, pick_word(), POS_W'($urandom), 70);
      end
    end
    queue_cmd(OP_INS_HEAD, $urandom, 8'd0, 70);
    queue_cmd(OP_INS_TAIL, $urandom, 8'd0, 70);
    queue_cmd(OP_READ_AT, 32'h0, 8'd255, 70);
    queue_cmd(OP_READ_TAIL, 32'h0, 8'd0, 70);
    queue_cmd(OP_READ_HEAD, 32'h0, 8'd0, 70);
    queue_cmd(OP_RM_AT, 32'h0, 8'd255, 70);
    queue_cmd(OP_INS_TAIL, $urandom, 8'd0, 70);
    queue_cmd(OP_RM_AT, 32'h0, 8'd0, 70);
    queue_cmd(OP_READ_AT, 32'h0, 8'd255, 70);

    // hold off until every outstanding result is back
    hold.req     = '0;
    hold.gap_pct = 0;
    hold.drain   = 1'b1;
    pending_cmds.push_back(hold);

    queue_random_ops(100, 0);
    queue_cmd(OP_CLEAR, 32'h0, 8'd0, 0);
    queue_random_ops(150, 38);

    repeat (4) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    while (pending_cmds.size() > 0 || start || expected_results.size() > 0) @(negedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (fail_count == 0) begin
      $display("bounded_array_list_core: match");
    end else begin
      $display("bounded_array_list_core: mismatch");
    end
    $finish;
  end

endmodule

// ===== bounded_array_list_core.f =====
rtl/bal_pkg.sv
rtl/bal_cell.sv
rtl/bal_grp.sv
rtl/bounded_array_list_core.sv
tb/sv/tb_bounded_array_list_core.sv
